// ----- design/dust_pkg.sv -----
`timescale 1ns / 1ps
package dust_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned IDX_W  = 3;

  // item operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_UNLOCK  = 2'd1;
  localparam logic [1:0] OP_LOCK    = 2'd2;
  localparam logic [1:0] OP_SILENCE = 2'd3;

  // lock reason codes
  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_CLOSE   = 2'd1;
  localparam logic [1:0] REASON_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_UNLOCK_TIMEOUT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_OPEN_HOLD_WARN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_AUTOLOCK_CLOSE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_UNLOCK_WARN      = 3'd3;
  localparam logic [IDX_W-1:0] REG_WARN_RETRIGGER   = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] RST_UNLOCK_TIMEOUT = 20'd15000;
  localparam logic [CFG_W-1:0] RST_OPEN_HOLD_WARN = 20'd30000;
  localparam logic [CFG_W-1:0] RST_AUTOLOCK_CLOSE = 20'd5000;
  localparam logic [CFG_W-1:0] RST_UNLOCK_WARN    = 20'd5000;
  localparam logic [CFG_W-1:0] RST_WARN_RETRIGGER = 20'd1000;

  // countdown warning leads
  localparam logic [CFG_W-1:0] CLOSE_LEAD = 20'd1000;
  localparam logic [CFG_W-1:0] HOLD_LEAD  = 20'd2000;

  typedef struct packed {
    logic [CFG_W-1:0] unlock_timeout;
    logic [CFG_W-1:0] open_hold_warn_after;
    logic [CFG_W-1:0] autolock_after_close;
    logic [CFG_W-1:0] unlock_warn_before;
    logic [CFG_W-1:0] warn_retrigger;
  } cfg_t;

  typedef struct packed {
    logic              session_active;
    logic              saw_open;
    logic              last_open;
    logic              hold_warn_silenced;
    logic [TIME_W-1:0] unlock_deadline;
    logic [TIME_W-1:0] open_warn_at;
    logic [TIME_W-1:0] close_lock_at;
    logic [TIME_W-1:0] next_warn_at;
  } state_t;

  localparam state_t STATE_IDLE = '0;

  typedef struct packed {
    logic              lock_door;
    logic              warn_beep;
    logic              silence_buzzer;
    logic [1:0]        lock_reason;
    logic              countdown_active;
    logic [TIME_W-1:0] countdown_deadline;
    logic [CFG_W-1:0]  countdown_warn_before;
  } result_t;

  // d is target minus now; true once now has reached target (wrap-safe)
  function automatic logic time_reached(input logic [TIME_W-1:0] d);
    return (d == '0) || (d[TIME_W-1] && (d[TIME_W-2:0] != '0));
  endfunction

  // d is target minus now; true while target lies strictly ahead
  function automatic logic time_ahead(input logic [TIME_W-1:0] d);
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

// ----- design/dust_in_if.sv -----
`timescale 1ns / 1ps
interface dust_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic        open_sense;
  logic        lock_sense;

  modport source (output valid, op, now_ms, open_sense, lock_sense, input ready);
  modport sink (input valid, op, now_ms, open_sense, lock_sense, output ready);
endinterface

// ----- design/dust_out_if.sv -----
`timescale 1ns / 1ps
interface dust_out_if;
  logic        valid;
  logic        ready;
  logic        lock_door;
  logic        warn_beep;
  logic        silence_buzzer;
  logic [1:0]  lock_reason;
  logic        countdown_active;
  logic [31:0] countdown_deadline;
  logic [19:0] countdown_warn_before;

  modport source (output valid, lock_door, warn_beep, silence_buzzer, lock_reason,
                  countdown_active, countdown_deadline, countdown_warn_before,
                  input ready);
  modport sink (input valid, lock_door, warn_beep, silence_buzzer, lock_reason,
                countdown_active, countdown_deadline, countdown_warn_before,
                output ready);
endinterface

// ----- design/door_unlock_session_timer_core.sv -----
`timescale 1ns / 1ps
// Door unlock session timer.
// in_ch carries one item per handshake: op (tick, unlock, lock, silence),
// the millisecond time and the door contact and lock sensor levels.
// out_ch returns exactly one result item per input item: lock, warn and
// silence strobes, the lock reason and the countdown view.
// cfg_wr_en / cfg_index / cfg_data write the five 20-bit timing registers;
// write them only while no item is in flight.
// Flow: an accepted item waits in the input register, moves to the result
// register and is offered on out_ch; an out_ch stall can hold it between.
// Throughput: one item per cycle unless out_ch stalls; the session state
// is updated in the same cycle that the result register is loaded, so the
// next item sees it.
// Reset (synchronous, rst_n low): session cleared, all deadlines unset,
// registers back to their defaults, both channels empty.
// When out_ch stalls, the result register holds and the input register
// keeps one item; in_ch.ready then drops until the result is taken.
module door_unlock_session_timer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  dust_in_if.sink                      in_ch,
  dust_out_if.source                   out_ch,
  input  logic                         cfg_wr_en,
  input  logic [dust_pkg::IDX_W-1:0]   cfg_index,
  input  logic [dust_pkg::CFG_W-1:0]   cfg_data
);

  dust_pkg::cfg_t    cfg_r;
  dust_pkg::state_t  state_r, state_nxt;
  dust_pkg::result_t step_res, res_r;

  logic                        in_valid_r;
  logic [1:0]                  op_r;
  logic [dust_pkg::TIME_W-1:0] now_r;
  logic                        open_r;
  logic                        locked_r;
  logic                        out_valid_r;
  logic                        adv;

  // item moves from input register to result register
  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unlock_timeout       <= dust_pkg::RST_UNLOCK_TIMEOUT;
      cfg_r.open_hold_warn_after <= dust_pkg::RST_OPEN_HOLD_WARN;
      cfg_r.autolock_after_close <= dust_pkg::RST_AUTOLOCK_CLOSE;
      cfg_r.unlock_warn_before   <= dust_pkg::RST_UNLOCK_WARN;
      cfg_r.warn_retrigger       <= dust_pkg::RST_WARN_RETRIGGER;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dust_pkg::REG_UNLOCK_TIMEOUT: cfg_r.unlock_timeout       <= cfg_data;
        dust_pkg::REG_OPEN_HOLD_WARN: cfg_r.open_hold_warn_after <= cfg_data;
        dust_pkg::REG_AUTOLOCK_CLOSE: cfg_r.autolock_after_close <= cfg_data;
        dust_pkg::REG_UNLOCK_WARN:    cfg_r.unlock_warn_before   <= cfg_data;
        dust_pkg::REG_WARN_RETRIGGER: cfg_r.warn_retrigger       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r     <= in_ch.op;
      now_r    <= in_ch.now_ms;
      open_r   <= in_ch.open_sense;
      locked_r <= in_ch.lock_sense;
    end
  end

  dust_step u_step (
    .st         (state_r),
    .cfg        (cfg_r),
    .op         (op_r),
    .now        (now_r),
    .open_sense (open_r),
    .lock_sense (locked_r),
    .st_nxt     (state_nxt),
    .res        (step_res)
  );

  // session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dust_pkg::STATE_IDLE;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.lock_door             = res_r.lock_door;
  assign out_ch.warn_beep             = res_r.warn_beep;
  assign out_ch.silence_buzzer        = res_r.silence_buzzer;
  assign out_ch.lock_reason           = res_r.lock_reason;
  assign out_ch.countdown_active      = res_r.countdown_active;
  assign out_ch.countdown_deadline    = res_r.countdown_deadline;
  assign out_ch.countdown_warn_before = res_r.countdown_warn_before;

`ifndef SYNTHESIS
  // a lock always ends the session
  a_lock_ends_session: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step_res.lock_door |=> !state_r.session_active)
    else $error("session still active after lock");

  // an auto-lock reason comes with lock and silence strobes
  a_reason_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.lock_reason != dust_pkg::REASON_NONE) |->
      res_r.lock_door && res_r.silence_buzzer)
    else $error("lock reason without lock strobes");

  // no warning beep together with a lock
  a_no_beep_on_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.warn_beep && res_r.lock_door))
    else $error("warn beep with lock");

  // a beep only comes from a tick within a session
  a_beep_source: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step_res.warn_beep |->
      (op_r == dust_pkg::OP_TICK) && state_r.session_active)
    else $error("beep outside an active tick");

  // countdown is never shown without a session
  a_countdown_session: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step_res.countdown_active |=> state_r.session_active)
    else $error("countdown without session");
`endif

endmodule

// ----- design/dust_step.sv -----
`timescale 1ns / 1ps
module dust_step (
  input  dust_pkg::state_t                 st,
  input  dust_pkg::cfg_t                   cfg,
  input  logic [1:0]                       op,
  input  logic [dust_pkg::TIME_W-1:0]      now,
  input  logic                             open_sense,
  input  logic                             lock_sense,
  output dust_pkg::state_t                 st_nxt,
  output dust_pkg::result_t                res
);

  localparam int unsigned TW  = dust_pkg::TIME_W;
  localparam int unsigned PAD = dust_pkg::TIME_W - dust_pkg::CFG_W;

  // distances from now to the stored deadlines
  logic [TW-1:0] d_ud_st, d_owa_st, d_cla_st, d_nwa_st;
  // configured intervals widened to time width
  logic [TW-1:0] ut_w, ohwa_w, aac_w, uwb_w, wr_w;
  logic          rise, fall;
  // tick view of the state after the door edge handling
  logic [TW-1:0] owa_t, d_owa_t, cla_t, d_cla_t, nwa_t;
  logic          saw_t, hws_t, due;
  // distances for the countdown after the update
  logic [TW-1:0] d_ud_n, d_owa_n, d_cla_n;
  logic [1:0]    reason;

  assign d_ud_st  = st.unlock_deadline - now;
  assign d_owa_st = st.open_warn_at - now;
  assign d_cla_st = st.close_lock_at - now;
  assign d_nwa_st = st.next_warn_at - now;

  assign ut_w   = {{PAD{1'b0}}, cfg.unlock_timeout};
  assign ohwa_w = {{PAD{1'b0}}, cfg.open_hold_warn_after};
  assign aac_w  = {{PAD{1'b0}}, cfg.autolock_after_close};
  assign uwb_w  = {{PAD{1'b0}}, cfg.unlock_warn_before};
  assign wr_w   = {{PAD{1'b0}}, cfg.warn_retrigger};

  assign rise = !st.last_open && open_sense;
  assign fall = st.last_open && !open_sense;

  // door edge handling: fresh deadlines carry their interval as distance
  always_comb begin
    owa_t   = st.open_warn_at;
    d_owa_t = d_owa_st;
    cla_t   = st.close_lock_at;
    d_cla_t = d_cla_st;
    nwa_t   = st.next_warn_at;
    saw_t   = st.saw_open;
    hws_t   = st.hold_warn_silenced;
    if (rise) begin
      saw_t   = 1'b1;
      hws_t   = 1'b0;
      owa_t   = now + ohwa_w;
      d_owa_t = ohwa_w;
      cla_t   = '0;
      nwa_t   = '0;
    end else if (fall) begin
      hws_t   = 1'b0;
      owa_t   = '0;
      cla_t   = now + aac_w;
      d_cla_t = aac_w;
      nwa_t   = '0;
    end
  end

  assign due = (nwa_t == '0) || dust_pkg::time_reached(d_nwa_st);

  // state update per operation
  always_comb begin
    st_nxt  = st;
    reason  = dust_pkg::REASON_NONE;
    res     = '0;
    d_ud_n  = d_ud_st;
    d_owa_n = d_owa_st;
    d_cla_n = d_cla_st;
    case (op)
      dust_pkg::OP_TICK: begin
        if (st.session_active) begin
          st_nxt.saw_open           = saw_t;
          st_nxt.hold_warn_silenced = hws_t;
          st_nxt.open_warn_at       = owa_t;
          st_nxt.close_lock_at      = cla_t;
          st_nxt.next_warn_at       = nwa_t;
          st_nxt.last_open          = open_sense;
          d_owa_n = d_owa_t;
          d_cla_n = d_cla_t;
          if (cla_t != '0) begin
            // close relock pending
            if (open_sense) begin
              st_nxt.close_lock_at = '0;
            end else if (dust_pkg::time_reached(d_cla_t)) begin
              st_nxt = dust_pkg::STATE_IDLE;
              reason = dust_pkg::REASON_CLOSE;
            end
          end else if (!saw_t) begin
            // door never opened since unlock
            if (dust_pkg::time_reached(d_ud_st)) begin
              st_nxt = dust_pkg::STATE_IDLE;
              reason = dust_pkg::REASON_TIMEOUT;
            end else if ((d_ud_st <= uwb_w) && due) begin
              res.warn_beep       = 1'b1;
              st_nxt.next_warn_at = now + wr_w;
            end
          end else if (open_sense && (owa_t != '0) && dust_pkg::time_reached(d_owa_t) &&
                       !hws_t && due) begin
            // door held open too long
            res.warn_beep       = 1'b1;
            st_nxt.next_warn_at = now + wr_w;
          end
        end
        if (reason != dust_pkg::REASON_NONE) begin
          res.lock_door      = 1'b1;
          res.silence_buzzer = 1'b1;
        end
      end
      dust_pkg::OP_UNLOCK: begin
        st_nxt.session_active     = 1'b1;
        st_nxt.saw_open           = open_sense;
        st_nxt.last_open          = open_sense;
        st_nxt.hold_warn_silenced = 1'b0;
        st_nxt.unlock_deadline    = now + ut_w;
        st_nxt.open_warn_at       = open_sense ? (now + ohwa_w) : '0;
        st_nxt.close_lock_at      = '0;
        st_nxt.next_warn_at       = '0;
        d_ud_n  = ut_w;
        d_owa_n = ohwa_w;
      end
      dust_pkg::OP_LOCK: begin
        st_nxt             = dust_pkg::STATE_IDLE;
        res.lock_door      = 1'b1;
        res.silence_buzzer = 1'b1;
      end
      dust_pkg::OP_SILENCE: begin
        if (st.session_active && open_sense) begin
          st_nxt.hold_warn_silenced = 1'b1;
        end
        res.silence_buzzer = 1'b1;
      end
      default: begin
        st_nxt = st;
      end
    endcase
    res.lock_reason = reason;

    // countdown view on the updated state
    if (st_nxt.session_active && !lock_sense) begin
      if ((st_nxt.close_lock_at != '0) && dust_pkg::time_ahead(d_cla_n)) begin
        res.countdown_active      = 1'b1;
        res.countdown_deadline    = st_nxt.close_lock_at;
        res.countdown_warn_before = dust_pkg::CLOSE_LEAD;
      end else if (!st_nxt.saw_open && dust_pkg::time_ahead(d_ud_n)) begin
        res.countdown_active      = 1'b1;
        res.countdown_deadline    = st_nxt.unlock_deadline;
        res.countdown_warn_before = cfg.unlock_warn_before;
      end else if (open_sense && (st_nxt.open_warn_at != '0) &&
                   dust_pkg::time_ahead(d_owa_n)) begin
        res.countdown_active      = 1'b1;
        res.countdown_deadline    = st_nxt.open_warn_at;
        res.countdown_warn_before = dust_pkg::HOLD_LEAD;
      end
    end
  end

endmodule
